// ----- rtl/core/crle_pkg.sv -----
// Shared types, constants and defaults for the Catmull-Rom loop evaluator.
package crle_pkg;

   localparam int MAX_POINTS_DEF  = 8;
   localparam int COORD_BITS_DEF  = 16;

   localparam int T_BITS          = 16;
   localparam int CNT_BITS        = 4;
   localparam logic [CNT_BITS-1:0] COUNT_RESET = 4'd5;

   localparam int OUT_BITS        = 24;
   localparam longint OUT_MAX     = 64'sd8388607;
   localparam longint OUT_MIN     = -64'sd8388608;
   localparam int ROUND_BIAS      = 256;
   localparam int ROUND_SHIFT     = 9;
   localparam int COEF_SHIFT      = 8;

   // queue between front and back; depth is a power of two
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
   localparam int QLVL_BITS       = $clog2(QUEUE_DEPTH + 1);
   localparam int FETCH_STAGES    = 2;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_EVAL  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                 empty;
      logic                 full;
      logic [QLVL_BITS-1:0] level;
   } queue_stat_type;

endpackage

// ----- rtl/core/catmull_rom_loop_evaluator.sv -----
// Top level of the closed-loop Catmull-Rom spline evaluator.
//
// Requests: an item is taken at a rising edge with start high and busy low.
// req_type selects a control-point write (slot req_point_index, Q8.8 x/y/z)
// or an evaluation at req_global_t (fraction of the whole loop, /65536).
// Writes give no result. An evaluation gives one result: position and
// derivative against local t, signed Q.8, saturated to 24 bits, shown on
// the rsp_ ports for exactly one cycle with rsp_valid high.
// Path: 2 fetch stages, then the queue, then 8 evaluation stages.
// Throughput: one item every cycle while busy is low; the four point
// fetches use one RAM copy per tap, so any mix of writes and evaluations
// streams without gaps.
// busy rises only when the front-to-back queue nears full; since the back
// end drains one entry per cycle it stays low in normal operation.
// csr_point_count sets the loop size (0 acts as 1, above MAX_POINTS as
// MAX_POINTS); csr_ready is always high. Write it only while idle.
// Reset clears the pipeline and sets the count to 5; the point store is
// not cleared and a slot must be written before an evaluation reads it.
// The receiver cannot stall: every result is a single-cycle transfer.
module catmull_rom_loop_evaluator #(
   parameter int MAX_POINTS = crle_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = crle_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_type,
   input  logic [2:0]                           req_point_index,
   input  logic signed [15:0]                   req_point_x,
   input  logic signed [15:0]                   req_point_y,
   input  logic signed [15:0]                   req_point_z,
   input  logic [crle_pkg::T_BITS-1:0]          req_global_t,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crle_pkg::CNT_BITS-1:0]        csr_point_count,
   output logic                                 rsp_valid,
   output logic signed [crle_pkg::OUT_BITS-1:0] rsp_pos_x,
   output logic signed [crle_pkg::OUT_BITS-1:0] rsp_pos_y,
   output logic signed [crle_pkg::OUT_BITS-1:0] rsp_pos_z,
   output logic signed [crle_pkg::OUT_BITS-1:0] rsp_slope_x,
   output logic signed [crle_pkg::OUT_BITS-1:0] rsp_slope_y,
   output logic signed [crle_pkg::OUT_BITS-1:0] rsp_slope_z
);

   import crle_pkg::*;

   localparam int QW = 12 * COORD_BITS + T_BITS;

   logic           accept;
   logic           push;
   logic [QW-1:0]  push_data;
   logic           pop;
   logic [QW-1:0]  head_data;
   queue_stat_type q_stat;
   logic signed [OUT_BITS-1:0] pos   [3];
   logic signed [OUT_BITS-1:0] slope [3];

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = (q_stat.level >= QLVL_BITS'(QUEUE_DEPTH - FETCH_STAGES));
   assign pop       = !q_stat.empty;

   crle_front #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_type        (req_type),
      .req_point_index (req_point_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_global_t    (req_global_t),
      .csr_write       (csr_valid && csr_ready),
      .csr_data        (csr_point_count),
      .push            (push),
      .push_data       (push_data)
   );

   crle_fifo #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .stat      (q_stat)
   );

   crle_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop),
      .in_data   (head_data),
      .out_valid (rsp_valid),
      .pos_out   (pos),
      .slope_out (slope)
   );

   assign rsp_pos_x   = pos[0];
   assign rsp_pos_y   = pos[1];
   assign rsp_pos_z   = pos[2];
   assign rsp_slope_x = slope[0];
   assign rsp_slope_y = slope[1];
   assign rsp_slope_z = slope[2];

endmodule

// ----- rtl/core/crle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module crle_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/crle_front.sv -----
// Front end: takes requests, stores control points, picks segment and fetches four points.
module crle_front #(
   parameter int MAX_POINTS = crle_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = crle_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               req_type,
   input  logic [2:0]                         req_point_index,
   input  logic signed [15:0]                 req_point_x,
   input  logic signed [15:0]                 req_point_y,
   input  logic signed [15:0]                 req_point_z,
   input  logic [crle_pkg::T_BITS-1:0]        req_global_t,
   input  logic                               csr_write,
   input  logic [crle_pkg::CNT_BITS-1:0]      csr_data,
   output logic                               push,
   output logic [12*COORD_BITS+crle_pkg::T_BITS-1:0] push_data
);

   import crle_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int PTW = 3 * COORD_BITS;

   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   logic [NW-1:0]        n_eff;
   logic [T_BITS+NW-1:0] scaled;
   logic [NW-1:0]        seg;
   logic [NW-1:0]        idx0;
   logic [NW-1:0]        idx2;
   logic [NW-1:0]        idx3;

   logic              f1_valid_ff;
   logic              f1_valid_in;
   logic [AW-1:0]     addr_ff [4];
   logic [AW-1:0]     addr_in [4];
   logic [T_BITS-1:0] frac1_ff;
   logic [T_BITS-1:0] frac1_in;
   logic              f2_valid_ff;
   logic [T_BITS-1:0] frac2_ff;

   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [PTW-1:0] wr_data;
   logic [PTW-1:0] tap_data [4];

   assign count_in = csr_write ? csr_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         n_eff = NW'(1);
      end else if (int'(count_ff) > MAX_POINTS) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = NW'(count_ff);
      end
      scaled = (T_BITS + NW)'(req_global_t) * (T_BITS + NW)'(n_eff);
      seg    = scaled[T_BITS +: NW];
      idx0   = (seg == '0) ? n_eff - NW'(1) : seg - NW'(1);
      idx2   = (seg + NW'(1) == n_eff) ? '0 : seg + NW'(1);
      idx3   = (idx2 + NW'(1) == n_eff) ? '0 : idx2 + NW'(1);
      addr_in[0] = AW'(idx0);
      addr_in[1] = AW'(seg);
      addr_in[2] = AW'(idx2);
      addr_in[3] = AW'(idx3);
      frac1_in   = scaled[T_BITS-1:0];
   end

   assign f1_valid_in = accept && (req_kind_type'(req_type) == REQ_EVAL);

   assign wr_en   = accept && (req_kind_type'(req_type) == REQ_WRITE)
                    && (int'(req_point_index) < MAX_POINTS);
   assign wr_addr = AW'(req_point_index);
   assign wr_data = {COORD_BITS'($unsigned(req_point_z)),
                     COORD_BITS'($unsigned(req_point_y)),
                     COORD_BITS'($unsigned(req_point_x))};

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      frac1_ff <= frac1_in;
      frac2_ff <= frac1_ff;
   end

   for (genvar k = 0; k < 4; k++) begin : g_tap
      crle_ram #(
         .WIDTH (PTW),
         .DEPTH (MAX_POINTS)
      ) u_store (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (f1_valid_ff),
         .rd_addr (addr_ff[k]),
         .rd_data (tap_data[k])
      );
   end

   assign push      = f2_valid_ff;
   assign push_data = {frac2_ff, tap_data[3], tap_data[2], tap_data[1], tap_data[0]};

endmodule

// ----- rtl/core/crle_fifo.sv -----
// Short queue between the fetch front end and the evaluation back end.
module crle_fifo #(
   parameter int WIDTH = 208
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         head_data,
   output crle_pkg::queue_stat_type stat
);

   import crle_pkg::*;

   logic [WIDTH-1:0]     mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QLVL_BITS-1:0] level_ff;
   logic [QLVL_BITS-1:0] level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      level_in  = level_ff;
      case ({push, pop})
         2'b10:   level_in = level_ff + QLVL_BITS'(1);
         2'b01:   level_in = level_ff - QLVL_BITS'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data  = mem_ff[rd_ptr_ff];
   assign stat.empty = (level_ff == '0);
   assign stat.full  = (level_ff == QLVL_BITS'(QUEUE_DEPTH));
   assign stat.level = level_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full) else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty) else $error("queue underflow");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !stat.empty) else $error("queue lost a transfer");

endmodule

// ----- rtl/core/crle_back.sv -----
// Back end: Catmull-Rom coefficients, Horner evaluation of position and slope, rounding.
module crle_back #(
   parameter int COORD_BITS = crle_pkg::COORD_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic [12*COORD_BITS+crle_pkg::T_BITS-1:0] in_data,
   output logic                                      out_valid,
   output logic signed [crle_pkg::OUT_BITS-1:0]      pos_out   [3],
   output logic signed [crle_pkg::OUT_BITS-1:0]      slope_out [3]
);

   import crle_pkg::*;

   localparam int CW  = COORD_BITS + 4;
   localparam int W   = COORD_BITS + 14;
   localparam int PW  = W + T_BITS + 1;
   localparam int LAT = 8;

   logic [LAT-1:0]    vld_ff;
   logic [LAT-1:0]    vld_in;
   logic [T_BITS-1:0] fr1_ff;
   logic [T_BITS-1:0] fr2_ff;
   logic [T_BITS-1:0] fr3_ff;
   logic [T_BITS-1:0] fr4_ff;
   logic [T_BITS-1:0] fr5_ff;

   assign vld_in = {vld_ff[LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fr1_ff <= in_data[12*COORD_BITS +: T_BITS];
      fr2_ff <= fr1_ff;
      fr3_ff <= fr2_ff;
      fr4_ff <= fr3_ff;
      fr5_ff <= fr4_ff;
   end

   assign out_valid = vld_ff[LAT-1];

   for (genvar ax = 0; ax < 3; ax++) begin : g_axis
      logic signed [CW-1:0] p0;
      logic signed [CW-1:0] p1;
      logic signed [CW-1:0] p2;
      logic signed [CW-1:0] p3;
      logic signed [CW-1:0] a3_in;
      logic signed [CW-1:0] a2_in;
      logic signed [CW-1:0] a1_in;
      logic signed [CW-1:0] a0_in;
      logic signed [CW-1:0] a3_1_ff;
      logic signed [CW-1:0] a2_1_ff;
      logic signed [CW-1:0] a1_1_ff;
      logic signed [CW-1:0] a0_1_ff;
      logic signed [CW-1:0] a2_2_ff;
      logic signed [CW-1:0] a1_2_ff;
      logic signed [CW-1:0] a0_2_ff;
      logic signed [CW-1:0] a1_3_ff;
      logic signed [CW-1:0] a0_3_ff;
      logic signed [CW-1:0] a1_4_ff;
      logic signed [CW-1:0] a0_4_ff;
      logic signed [CW-1:0] a0_5_ff;
      logic signed [CW-1:0] a0_6_ff;
      logic signed [W-1:0]  h0;
      logic signed [W-1:0]  g0;
      logic signed [PW-1:0] mh2_ff;
      logic signed [PW-1:0] mg2_ff;
      logic signed [W-1:0]  h3_ff;
      logic signed [W-1:0]  g3_ff;
      logic signed [PW-1:0] mh4_ff;
      logic signed [PW-1:0] mg4_ff;
      logic signed [W-1:0]  h5_ff;
      logic signed [W-1:0]  g5_ff;
      logic signed [PW-1:0] mh6_ff;
      logic signed [W-1:0]  g6_ff;
      logic signed [W-1:0]  h7_ff;
      logic signed [W-1:0]  g7_ff;
      logic signed [W-1:0]  h_rnd;
      logic signed [W-1:0]  g_rnd;
      logic signed [OUT_BITS-1:0] pos_in;
      logic signed [OUT_BITS-1:0] slope_in;
      logic signed [OUT_BITS-1:0] pos_ff;
      logic signed [OUT_BITS-1:0] slope_ff;

      always_comb begin
         p0 = CW'($signed(in_data[(0*3+ax)*COORD_BITS +: COORD_BITS]));
         p1 = CW'($signed(in_data[(1*3+ax)*COORD_BITS +: COORD_BITS]));
         p2 = CW'($signed(in_data[(2*3+ax)*COORD_BITS +: COORD_BITS]));
         p3 = CW'($signed(in_data[(3*3+ax)*COORD_BITS +: COORD_BITS]));
         a3_in = p3 - p0 + ((p1 - p2) <<< 1) + (p1 - p2);
         a2_in = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
         a1_in = p2 - p0;
         a0_in = p1 <<< 1;
         h0 = W'(a3_1_ff) <<< COEF_SHIFT;
         g0 = (W'(a3_1_ff) + (W'(a3_1_ff) <<< 1)) <<< COEF_SHIFT;
      end

      always_ff @(posedge clock) begin
         a3_1_ff <= a3_in;
         a2_1_ff <= a2_in;
         a1_1_ff <= a1_in;
         a0_1_ff <= a0_in;
         mh2_ff  <= PW'(h0) * PW'($signed({1'b0, fr1_ff}));
         mg2_ff  <= PW'(g0) * PW'($signed({1'b0, fr1_ff}));
         a2_2_ff <= a2_1_ff;
         a1_2_ff <= a1_1_ff;
         a0_2_ff <= a0_1_ff;
         h3_ff   <= mh2_ff[W+T_BITS-1:T_BITS] + (W'(a2_2_ff) <<< COEF_SHIFT);
         g3_ff   <= mg2_ff[W+T_BITS-1:T_BITS] + (W'(a2_2_ff) <<< (COEF_SHIFT + 1));
         a1_3_ff <= a1_2_ff;
         a0_3_ff <= a0_2_ff;
         mh4_ff  <= PW'(h3_ff) * PW'($signed({1'b0, fr3_ff}));
         mg4_ff  <= PW'(g3_ff) * PW'($signed({1'b0, fr3_ff}));
         a1_4_ff <= a1_3_ff;
         a0_4_ff <= a0_3_ff;
         h5_ff   <= mh4_ff[W+T_BITS-1:T_BITS] + (W'(a1_4_ff) <<< COEF_SHIFT);
         g5_ff   <= mg4_ff[W+T_BITS-1:T_BITS] + (W'(a1_4_ff) <<< COEF_SHIFT);
         a0_5_ff <= a0_4_ff;
         mh6_ff  <= PW'(h5_ff) * PW'($signed({1'b0, fr5_ff}));
         g6_ff   <= g5_ff;
         a0_6_ff <= a0_5_ff;
         h7_ff   <= mh6_ff[W+T_BITS-1:T_BITS] + (W'(a0_6_ff) <<< COEF_SHIFT);
         g7_ff   <= g6_ff;
         pos_ff   <= pos_in;
         slope_ff <= slope_in;
      end

      always_comb begin
         h_rnd = (h7_ff + W'(ROUND_BIAS)) >>> ROUND_SHIFT;
         g_rnd = (g7_ff + W'(ROUND_BIAS)) >>> ROUND_SHIFT;
         if (longint'(h_rnd) > OUT_MAX) begin
            pos_in = OUT_BITS'(OUT_MAX);
         end else if (longint'(h_rnd) < OUT_MIN) begin
            pos_in = OUT_BITS'(OUT_MIN);
         end else begin
            pos_in = OUT_BITS'(h_rnd);
         end
         if (longint'(g_rnd) > OUT_MAX) begin
            slope_in = OUT_BITS'(OUT_MAX);
         end else if (longint'(g_rnd) < OUT_MIN) begin
            slope_in = OUT_BITS'(OUT_MIN);
         end else begin
            slope_in = OUT_BITS'(g_rnd);
         end
      end

      assign pos_out[ax]   = pos_ff;
      assign slope_out[ax] = slope_ff;
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##LAT out_valid) else $error("result missing after pop");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, LAT)) else $error("result without popped item");

endmodule
